@@ hdl/jsfe_pkg.sv @@
// shared types, codes and helpers for the json string field extractor
package jsfe_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned KeyCharsW = 64;
  localparam int unsigned KeyLenW   = 4;
  localparam int unsigned CapW      = 16;
  localparam int unsigned CountW    = 16;
  localparam int unsigned SkipW     = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  localparam logic [SkipW-1:0] SkipLen = 3'd4;

  localparam logic [ByteW-1:0] ChQuote = 8'h22;
  localparam logic [ByteW-1:0] ChColon = 8'h3A;
  localparam logic [ByteW-1:0] ChBslash = 8'h5C;
  localparam logic [ByteW-1:0] ChSlash = 8'h2F;
  localparam logic [ByteW-1:0] ChN     = 8'h6E;
  localparam logic [ByteW-1:0] ChR     = 8'h72;
  localparam logic [ByteW-1:0] ChT     = 8'h74;
  localparam logic [ByteW-1:0] ChU     = 8'h75;
  localparam logic [ByteW-1:0] ChLf    = 8'h0A;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChNul   = 8'h00;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_CHARS  = 2'd0,
    REG_KEY_LENGTH = 2'd1,
    REG_VALUE_CAP  = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_BYTE  = 3'd0,
    ST_QUOTE = 3'd1,
    ST_FULL  = 3'd2,
    ST_ENDED = 3'd3,
    ST_NOKEY = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    PH_SEARCH = 5'b00001,
    PH_VALUE  = 5'b00010,
    PH_ESCAPE = 5'b00100,
    PH_SKIP   = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] value_byte;
    status_e          status;
    logic             run_last;
  } result_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctrl_t;

  // expected byte at place i of  " key " : "  for a key of klen characters
  function automatic logic [ByteW-1:0] pattern_byte(input int unsigned i,
                                                    input int unsigned klen,
                                                    input logic [KeyCharsW-1:0] key);
    logic [2:0] sel;
    logic [ByteW-1:0] res;
    sel = 3'(i - 1);
    if (i == 0) begin
      res = ChQuote;
    end else if (i <= klen) begin
      res = key[{sel, 3'b000} +: ByteW];
    end else if (i == klen + 1) begin
      res = ChQuote;
    end else if (i == klen + 2) begin
      res = ChColon;
    end else begin
      res = ChQuote;
    end
    return res;
  endfunction

endpackage

@@ hdl/jsfe_window.sv @@
// sliding byte window and key pattern compare
module jsfe_window #(
  parameter int unsigned KeyMax = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  jsfe_pkg::win_ctrl_t           ctrl_i,
  input  logic [jsfe_pkg::ByteW-1:0]    byte_i,
  input  logic [jsfe_pkg::KeyCharsW-1:0] key_chars_i,
  input  logic [jsfe_pkg::KeyLenW-1:0]  key_length_i,
  output logic                          match_o
);
  import jsfe_pkg::*;

  localparam int unsigned WinDepth = KeyMax + 4;
  localparam int unsigned SeenW    = $clog2(WinDepth + 1);

  logic [ByteW-1:0] win_q [WinDepth];
  logic [ByteW-1:0] win_d [WinDepth];
  logic [SeenW-1:0] seen_q, seen_d;
  logic [SeenW-1:0] plen;
  int unsigned      klen;

  // window as it stands once the incoming byte is shifted in
  always_comb begin
    for (int j = 0; j < WinDepth; j++) begin
      if (j == WinDepth - 1) begin
        win_d[j] = byte_i;
      end else begin
        win_d[j] = win_q[j+1];
      end
    end
    seen_d = (seen_q < SeenW'(WinDepth)) ? seen_q + 1'b1 : seen_q;
  end

  always_comb begin
    klen = (int'(key_length_i) > KeyMax) ? KeyMax : int'(key_length_i);
    plen = SeenW'(klen + 4);
    match_o = (seen_d >= plen);
    for (int j = 0; j < WinDepth; j++) begin
      if (j >= int'(WinDepth) - int'(plen)) begin
        if (win_d[j] != pattern_byte(j - (WinDepth - int'(plen)), klen, key_chars_i)) begin
          match_o = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      for (int j = 0; j < WinDepth; j++) win_q[j] <= '0;
    end else if (ctrl_i.clear) begin
      seen_q <= '0;
      for (int j = 0; j < WinDepth; j++) win_q[j] <= '0;
    end else if (ctrl_i.shift) begin
      seen_q <= seen_d;
      for (int j = 0; j < WinDepth; j++) win_q[j] <= win_d[j];
    end
  end

endmodule

@@ hdl/jsfe_decode.sv @@
// value phase sequencer and escape decode
module jsfe_decode (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic [jsfe_pkg::ByteW-1:0] byte_i,
  input  logic                       fend_i,
  input  logic                       match_i,
  input  logic [jsfe_pkg::CapW-1:0]  value_capacity_i,
  output jsfe_pkg::win_ctrl_t        win_ctrl_o,
  output logic [1:0]                 push_o,
  output jsfe_pkg::result_t          byte_res_o,
  output jsfe_pkg::result_t          stat_res_o
);
  import jsfe_pkg::*;

  phase_e            phase_q, phase_d;
  logic [SkipW-1:0]  skip_q, skip_d;
  logic [CountW-1:0] emit_q, emit_d;
  logic              stop;
  status_e           st;
  logic              push_byte;
  logic [ByteW-1:0]  out_byte;
  logic              full_next;
  logic              esc_emit;
  logic [ByteW-1:0]  esc_byte;

  // capacity check on the count after this byte
  assign full_next = ({1'b0, emit_q} + 17'd2) >= {1'b0, value_capacity_i};

  always_comb begin
    esc_emit = 1'b1;
    esc_byte = byte_i;
    case (byte_i)
      ChN:      esc_byte = ChLf;
      ChR:      esc_byte = ChCr;
      ChT:      esc_byte = ChTab;
      ChQuote:  esc_byte = ChQuote;
      ChBslash: esc_byte = ChBslash;
      ChSlash:  esc_byte = ChSlash;
      default:  esc_emit = 1'b0;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    skip_d    = skip_q;
    emit_d    = emit_q;
    stop      = 1'b0;
    st        = ST_BYTE;
    push_byte = 1'b0;
    out_byte  = byte_i;
    win_ctrl_o.shift = 1'b0;
    win_ctrl_o.clear = adv_i & fend_i;
    if (adv_i) begin
      unique case (phase_q)
        PH_SEARCH: begin
          if (byte_i == ChNul) begin
            stop = 1'b1;
            st   = ST_NOKEY;
          end else begin
            win_ctrl_o.shift = 1'b1;
            if (match_i) begin
              phase_d = PH_VALUE;
              emit_d  = '0;
              if (value_capacity_i <= CapW'(1)) begin
                stop = 1'b1;
                st   = ST_FULL;
              end
            end
          end
        end
        PH_VALUE: begin
          if (byte_i == ChNul) begin
            stop = 1'b1;
            st   = ST_ENDED;
          end else if (byte_i == ChQuote) begin
            stop = 1'b1;
            st   = ST_QUOTE;
          end else if (byte_i == ChBslash && !fend_i) begin
            phase_d = PH_ESCAPE;
          end else begin
            push_byte = 1'b1;
            emit_d    = emit_q + 1'b1;
            if (full_next) begin
              stop = 1'b1;
              st   = ST_FULL;
            end
          end
        end
        PH_ESCAPE: begin
          phase_d = PH_VALUE;
          if (byte_i == ChNul) begin
            // lone backslash before the end of text is kept
            push_byte = 1'b1;
            out_byte  = ChBslash;
            emit_d    = emit_q + 1'b1;
            stop      = 1'b1;
            st        = ST_ENDED;
          end else if (byte_i == ChU) begin
            phase_d = PH_SKIP;
            skip_d  = SkipLen;
          end else if (esc_emit) begin
            push_byte = 1'b1;
            out_byte  = esc_byte;
            emit_d    = emit_q + 1'b1;
            if (full_next) begin
              stop = 1'b1;
              st   = ST_FULL;
            end
          end
        end
        PH_SKIP: begin
          if (byte_i == ChNul) begin
            stop = 1'b1;
            st   = ST_ENDED;
          end else begin
            skip_d = skip_q - 1'b1;
            if (skip_q == SkipW'(1)) phase_d = PH_VALUE;
          end
        end
        PH_DONE: begin
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase

      if (!stop && fend_i) begin
        if (phase_d == PH_SEARCH) begin
          stop = 1'b1;
          st   = ST_NOKEY;
        end else if (phase_d != PH_DONE) begin
          stop = 1'b1;
          st   = ST_ENDED;
        end
      end
      if (stop) phase_d = PH_DONE;
      if (fend_i) begin
        phase_d = PH_SEARCH;
        skip_d  = '0;
        emit_d  = '0;
      end
    end
  end

  assign push_o = {stop, push_byte};

  assign byte_res_o.value_byte = out_byte;
  assign byte_res_o.status     = ST_BYTE;
  assign byte_res_o.run_last   = 1'b0;
  assign stat_res_o.value_byte = '0;
  assign stat_res_o.status     = st;
  assign stat_res_o.run_last   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      skip_q  <= '0;
      emit_q  <= '0;
    end else begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      emit_q  <= emit_d;
    end
  end

  a_no_byte_when_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_byte |-> (phase_q == PH_VALUE || phase_q == PH_ESCAPE))
    else $error("value byte produced outside the value");

  a_skip_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP) |-> (skip_q != '0))
    else $error("skip phase with nothing left to skip");

  a_frame_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && fend_i) |=> (phase_q == PH_SEARCH && emit_q == '0))
    else $error("frame end did not restart the search");

endmodule

@@ hdl/jsfe_result_fifo.sv @@
// small result queue taking up to two results per cycle
module jsfe_result_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [1:0]                    push_i,
  input  jsfe_pkg::result_t             res0_i,
  input  jsfe_pkg::result_t             res1_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output jsfe_pkg::result_t             head_o,
  output logic [jsfe_pkg::FifoCntW-1:0] count_o
);
  import jsfe_pkg::*;

  result_t             mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, rd_q;
  logic [FifoCntW-1:0] cnt_q;
  logic                do_pop;
  logic [FifoCntW-1:0] n_push;

  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign count_o = cnt_q;
  assign do_pop  = pop_i & valid_o;
  assign n_push  = FifoCntW'(push_i[0]) + FifoCntW'(push_i[1]);

  always_ff @(posedge clk_i) begin
    if (push_i[0]) begin
      mem_q[wr_q] <= res0_i;
      if (push_i[1]) mem_q[wr_q + 1'b1] <= res1_i;
    end else if (push_i[1]) begin
      mem_q[wr_q] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + FifoPtrW'(n_push);
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + n_push - FifoCntW'(do_pop);
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i != 2'b00) |-> (cnt_q <= FifoCntW'(FifoDepth - 2)))
    else $error("result queue written without room");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FifoCntW'(FifoDepth))
    else $error("result queue count out of range");

  a_pop_moves_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop |=> (rd_q == $past(rd_q) + 1'b1))
    else $error("read pointer did not advance");

endmodule

@@ hdl/json_string_field_extractor.sv @@
// top level of the streaming json string field extractor
// Takes a JSON text one byte per input transaction (tlast marks the last byte of a
// document) and looks for the first  "key":"  sequence, the key set through the
// configuration channel. After it, the decoded string value leaves one byte per output
// transaction with tuser = 0, and every run closes with one status transaction carrying
// tlast (1 closed by quote, 2 capacity reached, 3 text ended inside value, 4 key not
// found). Each input byte passes an input register and is decoded there, once the queue
// has room for a byte and a status, by the window compare and the escape decoder, which
// write their results into a four-entry result queue whose head drives the output.
// Sustained rate is one byte per cycle; a byte that yields both a value byte and a status
// needs two output transactions, and tready drops while a byte waits in the input
// register and the queue holds more than two results.
// The user writes configuration registers only while no document is in flight; the block does not enforce this.
module json_string_field_extractor #(
  parameter int unsigned KeyMax = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // text input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  input  logic        s_axis_tlast_i,   // frame_end
  // decoded value stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] value_byte
  output logic [2:0]  m_axis_tuser_o,   // [2:0] status
  output logic        m_axis_tlast_o,   // run_last
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [jsfe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [jsfe_pkg::CfgDataW-1:0] cfg_data_i
);
  import jsfe_pkg::*;

  // configuration registers
  logic [KeyCharsW-1:0] key_chars_q;
  logic [KeyLenW-1:0]   key_length_q;
  logic [CapW-1:0]      value_cap_q;

  // input register
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_fend_q;

  logic                adv;
  logic                match;
  win_ctrl_t           win_ctrl;
  logic [1:0]          push;
  result_t             byte_res, stat_res, head;
  logic                q_valid;
  logic [FifoCntW-1:0] q_count;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_chars_q  <= '0;
      key_length_q <= KeyLenW'(1);
      value_cap_q  <= CapW'(256);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_KEY_CHARS:  key_chars_q  <= cfg_data_i;
        REG_KEY_LENGTH: key_length_q <= cfg_data_i[KeyLenW-1:0];
        REG_VALUE_CAP:  value_cap_q  <= cfg_data_i[CapW-1:0];
        default: begin
          // writes past the register list are dropped
        end
      endcase
    end
  end

  // decode advances only when the queue can take a byte and a status
  assign adv             = in_valid_q & (q_count <= FifoCntW'(FifoDepth - 2));
  assign s_axis_tready_o = ~in_valid_q | adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_fend_q <= s_axis_tlast_i;
    end
  end

  jsfe_window #(
    .KeyMax (KeyMax)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (win_ctrl),
    .byte_i       (in_byte_q),
    .key_chars_i  (key_chars_q),
    .key_length_i (key_length_q),
    .match_o      (match)
  );

  jsfe_decode u_decode (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .adv_i            (adv),
    .byte_i           (in_byte_q),
    .fend_i           (in_fend_q),
    .match_i          (match),
    .value_capacity_i (value_cap_q),
    .win_ctrl_o       (win_ctrl),
    .push_o           (push),
    .byte_res_o       (byte_res),
    .stat_res_o       (stat_res)
  );

  jsfe_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res0_i  (byte_res),
    .res1_i  (stat_res),
    .pop_i   (m_axis_tready_i),
    .valid_o (q_valid),
    .head_o  (head),
    .count_o (q_count)
  );

  assign m_axis_tvalid_o = q_valid;
  assign m_axis_tdata_o  = head.value_byte;
  assign m_axis_tuser_o  = head.status;
  assign m_axis_tlast_o  = head.run_last;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the json string field extractor with a built-in predictor
module tb;
  import jsfe_pkg::*;

  localparam int unsigned WinDepth       = 12;     // key of up to eight plus four framing bytes
  localparam int unsigned KeyCap         = 8;
  localparam int unsigned DrainCycles    = 12;     // input register, decode and result queue
  localparam int unsigned CycleLimit     = 500000;
  localparam int unsigned HoldCycles     = 400;
  localparam int unsigned HoldAfterItems = 1000;
  localparam int unsigned QuietFrom      = 400;    // window of accepted bytes with no idling
  localparam int unsigned QuietTo        = 800;
  localparam int unsigned RandomPhases   = 8;
  localparam int unsigned PhaseBytes     = 220;

  typedef struct packed {
    logic [ByteW-1:0] txt;
    logic             eof;
  } text_item_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // block ports
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i  = '0;
  logic                s_axis_tlast_i  = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [7:0]          m_axis_tdata_o;
  logic [2:0]          m_axis_tuser_o;
  logic                m_axis_tlast_o;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  cfg_reg_e            cfg_index_i     = REG_KEY_CHARS;
  logic [CfgDataW-1:0] cfg_data_i      = '0;

  json_string_field_extractor dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // pending text bytes, frame under construction, expected value and status results
  text_item_t        text_q[$];
  logic [ByteW-1:0]  frame_q[$];
  result_t           value_q[$];

  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;

  // predictor copy of the registers and of the scan state
  logic [KeyCharsW-1:0] cur_key_chars;
  logic [KeyLenW-1:0]   cur_key_len;
  logic [CapW-1:0]      cur_capacity;
  logic [ByteW-1:0]     hist [WinDepth];
  int unsigned          hist_fill;
  phase_e               scan_phase;
  logic [SkipW-1:0]     hex_left;
  int unsigned          value_len;

  function automatic void restart_scan();
    for (int k = 0; k < WinDepth; k++) hist[k] = '0;
    hist_fill  = 0;
    scan_phase = PH_SEARCH;
    hex_left   = '0;
    value_len  = 0;
  endfunction

  function automatic int unsigned key_span();
    return (cur_key_len > KeyCap) ? KeyCap : cur_key_len;
  endfunction

  // tail of the history against  " key " : "
  function automatic logic key_pattern_seen();
    int unsigned klen;
    int unsigned plen;
    logic [ByteW-1:0] want;
    logic hit;
    klen = key_span();
    plen = klen + 4;
    hit  = (hist_fill >= plen);
    for (int unsigned i = 0; i < plen; i++) begin
      if (i == 0 || i == klen + 1 || i >= klen + 3) want = ChQuote;
      else if (i <= klen) want = cur_key_chars[8*(i-1) +: 8];
      else want = ChColon;
      if (hist[WinDepth-plen+i] != want) hit = 1'b0;
    end
    return hit;
  endfunction

  function automatic logic value_full();
    return (value_len + 1) >= cur_capacity;
  endfunction

  function automatic void expect_result(input logic [ByteW-1:0] v, input status_e st,
                                        input logic rl);
    result_t r;
    r.value_byte = v;
    r.status     = st;
    r.run_last   = rl;
    value_q.push_back(r);
  endfunction

  // expected results of one accepted text byte
  function automatic void decode_text_byte(input logic [ByteW-1:0] b, input logic fend);
    logic             stop;
    status_e          st;
    logic [ByteW-1:0] d;
    logic             emit;
    stop = 1'b0;
    st   = ST_BYTE;
    d    = '0;
    emit = 1'b1;
    case (scan_phase)
      PH_SEARCH: begin
        if (b == ChNul) begin
          stop = 1'b1;
          st   = ST_NOKEY;
        end else begin
          for (int k = 0; k < WinDepth - 1; k++) hist[k] = hist[k+1];
          hist[WinDepth-1] = b;
          if (hist_fill < WinDepth) hist_fill++;
          if (key_pattern_seen()) begin
            scan_phase = PH_VALUE;
            value_len  = 0;
            // tiny capacity closes the value right at the match
            if (value_full()) begin
              stop = 1'b1;
              st   = ST_FULL;
            end
          end
        end
      end
      PH_VALUE: begin
        if (b == ChNul) begin
          stop = 1'b1;
          st   = ST_ENDED;
        end else if (b == ChQuote) begin
          stop = 1'b1;
          st   = ST_QUOTE;
        end else if (b == ChBslash && !fend) begin
          scan_phase = PH_ESCAPE;
        end else begin
          // a backslash carrying the frame end lands here and is kept
          expect_result(b, ST_BYTE, 1'b0);
          value_len++;
          if (value_full()) begin
            stop = 1'b1;
            st   = ST_FULL;
          end
        end
      end
      PH_ESCAPE: begin
        scan_phase = PH_VALUE;
        if (b == ChNul) begin
          expect_result(ChBslash, ST_BYTE, 1'b0);
          value_len++;
          stop = 1'b1;
          st   = ST_ENDED;
        end else begin
          case (b)
            ChN:                        d = ChLf;
            ChR:                        d = ChCr;
            ChT:                        d = ChTab;
            ChQuote, ChBslash, ChSlash: d = b;
            ChU: begin
              emit       = 1'b0;
              scan_phase = PH_SKIP;
              hex_left   = SkipLen;
            end
            default:                    emit = 1'b0;
          endcase
          if (emit) begin
            expect_result(d, ST_BYTE, 1'b0);
            value_len++;
            if (value_full()) begin
              stop = 1'b1;
              st   = ST_FULL;
            end
          end
        end
      end
      PH_SKIP: begin
        if (b == ChNul) begin
          stop = 1'b1;
          st   = ST_ENDED;
        end else begin
          if (hex_left > 0) hex_left--;
          if (hex_left == 0) scan_phase = PH_VALUE;
        end
      end
      default: ;
    endcase
    if (!stop && fend) begin
      if (scan_phase == PH_SEARCH) begin
        stop = 1'b1;
        st   = ST_NOKEY;
      end else if (scan_phase != PH_DONE) begin
        stop = 1'b1;
        st   = ST_ENDED;
      end
    end
    if (stop) begin
      expect_result('0, st, 1'b1);
      scan_phase = PH_DONE;
    end
    if (fend) restart_scan();
  endfunction

  // text driver: takes the next pending byte once the current transaction is gone
  always @(posedge clk_i or negedge rst_ni) begin
    text_item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tlast_i  <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        decode_text_byte(s_axis_tdata_i, s_axis_tlast_i);
        items_sent <= items_sent + 1;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (text_q.size() != 0 &&
            ((items_sent >= QuietFrom && items_sent < QuietTo) || $urandom_range(99) >= 6)) begin
          nxt = text_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= nxt.txt;
          s_axis_tlast_i  <= nxt.eof;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // result receiver: random stalls, one long hold-off in the middle of the random traffic
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      hold_left       <= 0;
      hold_done       <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left       <= hold_left - 1;
    end else if (!hold_done && items_sent >= HoldAfterItems) begin
      m_axis_tready_i <= 1'b0;
      hold_left       <= HoldCycles;
      hold_done       <= 1'b1;
    end else begin
      m_axis_tready_i <= (items_sent >= QuietFrom && items_sent < QuietTo) ||
                         ($urandom_range(99) >= 6);
    end
  end

  function automatic void flag_error(input string what, input int unsigned want,
                                     input int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endfunction

  // result monitor: each result transaction against the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (value_q.size() == 0) begin
        flag_error("unexpected result", 0, m_axis_tdata_o);
      end else begin
        want = value_q.pop_front();
        if (m_axis_tdata_o !== want.value_byte)
          flag_error("value_byte", want.value_byte, m_axis_tdata_o);
        if (m_axis_tuser_o !== want.status)
          flag_error("status", want.status, m_axis_tuser_o);
        if (m_axis_tlast_o !== want.run_last)
          flag_error("run_last", want.run_last, m_axis_tlast_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // stimulus helpers
  function automatic logic [ByteW-1:0] text_char(input logic wide);
    logic [ByteW-1:0] c;
    do begin
      c = wide ? 8'($urandom_range(255, 1)) : 8'($urandom_range(126, 32));
    end while (c == ChQuote || c == ChBslash);
    return c;
  endfunction

  function automatic void add_text(input string s);
    for (int k = 0; k < s.len(); k++) frame_q.push_back(s[k]);
  endfunction

  // first upto bytes of  " key " : "  for the current key
  function automatic void add_key_pattern(input int unsigned upto);
    int unsigned klen;
    logic [ByteW-1:0] c;
    klen = key_span();
    for (int unsigned i = 0; i < upto && i < klen + 4; i++) begin
      if (i == 0 || i == klen + 1 || i >= klen + 3) c = ChQuote;
      else if (i <= klen) c = cur_key_chars[8*(i-1) +: 8];
      else c = ChColon;
      frame_q.push_back(c);
    end
  endfunction

  function automatic void add_value_body(input int unsigned n);
    int unsigned r;
    logic [ByteW-1:0] esc [6];
    logic [ByteW-1:0] c;
    esc = '{ChN, ChR, ChT, ChQuote, ChBslash, ChSlash};
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 58) begin
        frame_q.push_back(text_char(1'b0));
      end else if (r < 76) begin
        frame_q.push_back(ChBslash);
        frame_q.push_back(esc[$urandom_range(5)]);
      end else if (r < 82) begin
        // unicode escape, the four skipped bytes may be anything but zero
        frame_q.push_back(ChBslash);
        frame_q.push_back(ChU);
        repeat (4) frame_q.push_back(8'($urandom_range(255, 1)));
      end else if (r < 88) begin
        do begin
          c = 8'($urandom_range(255, 1));
        end while (c == ChN || c == ChR || c == ChT || c == ChQuote || c == ChBslash ||
                   c == ChSlash || c == ChU);
        frame_q.push_back(ChBslash);
        frame_q.push_back(c);
      end else begin
        frame_q.push_back(text_char(1'b1));
      end
    end
  endfunction

  // moves the frame to the driver, tlast on its final byte; split pauses half way
  task automatic ship_frame(input logic split);
    text_item_t it;
    int unsigned n;
    n = frame_q.size();
    for (int unsigned k = 0; k < n; k++) begin
      if (split && k == n / 2) wait_idle();
      it.txt = frame_q[k];
      it.eof = (k == n - 1);
      text_q.push_back(it);
    end
    frame_q.delete();
  endtask

  task automatic wait_idle();
    while (text_q.size() != 0 || s_axis_tvalid_i || value_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_KEY_CHARS:  cur_key_chars = val;
      REG_KEY_LENGTH: cur_key_len   = val[KeyLenW-1:0];
      REG_VALUE_CAP:  cur_capacity  = val[CapW-1:0];
      default: ;
    endcase
  endtask

  // only called with nothing in flight, so the predictor copy changes safely here
  task automatic set_config(input logic [CfgDataW-1:0] key, input logic [CfgDataW-1:0] klen,
                            input logic [CfgDataW-1:0] cap);
    wait_idle();
    write_reg(REG_KEY_CHARS, key);
    write_reg(REG_KEY_LENGTH, klen);
    write_reg(REG_VALUE_CAP, cap);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [CfgDataW-1:0] key_val;
    logic [CfgDataW-1:0] len_val;
    logic [CfgDataW-1:0] cap_val;
    int unsigned         r;
    int unsigned         phase_start;
    int unsigned         frames;

    cur_key_chars = '0;
    cur_key_len   = 4'd1;
    cur_capacity  = 16'd256;
    restart_scan();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: the key is a single zero character, so nothing matches
    add_text("\"x\":\"ab");
    ship_frame(1'b0);
    add_text("q");
    frame_q.push_back(ChNul);
    add_text("\"x");
    ship_frame(1'b0);

    set_config(64'h6B, 64'd1, 64'd256);
    // every escape, unicode skip, unknown escape, then a second match that is ignored
    add_text("\"k\":\"a\\n\\r\\t\\\"\\\\\\/\\u00e9\\qz\"tail\"k\":\"zz");
    ship_frame(1'b0);
    add_text("\"k\":\"ab");
    ship_frame(1'b0);
    // backslash as the final byte, then backslash before a zero byte
    add_text("\"k\":\"a\\");
    ship_frame(1'b0);
    add_text("\"k\":\"a\\");
    frame_q.push_back(ChNul);
    ship_frame(1'b0);
    // text ends inside the unicode skip
    add_text("\"k\":\"\\u12");
    ship_frame(1'b0);
    add_text("\"k\":\"\\u1");
    frame_q.push_back(ChNul);
    add_text("x");
    ship_frame(1'b0);
    add_text("\"k\":\"");
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'h80);
    frame_q.push_back(8'h7F);
    frame_q.push_back(8'h01);
    frame_q.push_back(ChNul);
    ship_frame(1'b0);
    // match on the byte that ends the frame
    add_text("\"k\":\"");
    ship_frame(1'b0);

    // empty key with capacity one and zero: full right at the match
    set_config(64'h0, 64'd0, 64'd1);
    add_text("\"\":\"x\"");
    ship_frame(1'b0);
    set_config(64'h0, 64'd0, 64'd0);
    add_text("\"\":\"x\"");
    ship_frame(1'b0);
    // capacity reached by a plain byte, by an escape, and on the frame end byte
    set_config(64'h0, 64'd0, 64'd3);
    add_text("\"\":\"abcdef\"");
    ship_frame(1'b0);
    add_text("\"\":\"a\\n\"");
    ship_frame(1'b0);
    add_text("\"\":\"ab");
    ship_frame(1'b0);

    // key length above the maximum saturates, key of all-ones bytes
    set_config('1, 64'd15, 64'd65535);
    frame_q.push_back(ChQuote);
    repeat (KeyCap) frame_q.push_back(8'hFF);
    add_text("\":\"value\"");
    ship_frame(1'b0);
    set_config(64'h0, 64'd8, 64'd65535);
    add_text("\"ab\":\"c\"");
    ship_frame(1'b0);

    // random phases
    for (int unsigned p = 0; p < RandomPhases; p++) begin
      for (int k = 0; k < KeyCap; k++)
        key_val[8*k +: 8] = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 1))
                                                     : text_char(1'b0);
      len_val = {$urandom, $urandom};
      r = $urandom_range(9);
      if (r == 0) len_val[KeyLenW-1:0] = '0;
      else if (r == 1) len_val[KeyLenW-1:0] = 4'($urandom_range(15, 9));
      else len_val[KeyLenW-1:0] = 4'($urandom_range(8, 1));
      cap_val = {$urandom, $urandom};
      r = $urandom_range(9);
      if (r == 0) cap_val[CapW-1:0] = 16'($urandom_range(1));
      else if (r <= 4) cap_val[CapW-1:0] = 16'($urandom_range(16, 2));
      else if (r <= 6) cap_val[CapW-1:0] = 16'd256;
      else if (r == 7) cap_val[CapW-1:0] = 16'd65535;
      else cap_val[CapW-1:0] = 16'($urandom_range(64, 17));
      set_config(key_val, len_val, cap_val);

      phase_start = items_sent + text_q.size();
      frames = 0;
      while (items_sent + text_q.size() < phase_start + PhaseBytes) begin
        if ($urandom_range(99) < 75) begin
          // well-formed: prefix, pattern, value, then one of the ways a value can end
          repeat ($urandom_range(4))
            frame_q.push_back(($urandom_range(5) == 0) ? ChQuote : text_char(1'b1));
          add_key_pattern(KeyCap + 4);
          add_value_body(($urandom_range(7) == 0) ? $urandom_range(40, 10) : $urandom_range(8));
          r = $urandom_range(9);
          if (r <= 4) begin
            frame_q.push_back(ChQuote);
            repeat ($urandom_range(3)) frame_q.push_back(text_char(1'b1));
            if ($urandom_range(3) == 0) begin
              add_key_pattern(KeyCap + 4);
              add_value_body(2);
            end
          end else if (r == 5) begin
            frame_q.push_back(ChNul);
            repeat ($urandom_range(2)) frame_q.push_back(text_char(1'b1));
          end else if (r == 6) begin
            frame_q.push_back(text_char(1'b1));
          end else if (r == 7) begin
            frame_q.push_back(ChBslash);
          end else if (r == 8) begin
            frame_q.push_back(ChBslash);
            frame_q.push_back(ChNul);
          end else begin
            frame_q.push_back(ChBslash);
            frame_q.push_back(ChU);
            repeat ($urandom_range(3)) frame_q.push_back(8'($urandom_range(255, 1)));
            if ($urandom_range(1) == 0) frame_q.push_back(ChNul);
          end
        end else begin
          // noise with quotes and colons, often a truncated pattern, sometimes a zero
          repeat ($urandom_range(12, 1)) begin
            r = $urandom_range(9);
            if (r < 2) frame_q.push_back(ChQuote);
            else if (r < 3) frame_q.push_back(ChColon);
            else if (r < 5) frame_q.push_back(8'($urandom_range(255, 1)));
            else frame_q.push_back(text_char(1'b0));
          end
          if ($urandom_range(1) == 0) add_key_pattern($urandom_range(key_span() + 3, 1));
          if ($urandom_range(6) == 0) frame_q.push_back(ChNul);
          frame_q.push_back(text_char(1'b1));
        end
        // once, the sender stops mid-frame until every expected result is out
        ship_frame(p == 1 && frames == 3);
        frames++;
      end
    end

    wait_idle();
    if (mismatches == 0 && value_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
